// ----- hw/rtl/pwpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PWM pulse width capture package
// Item types, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pwpc_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNTER_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_PERIOD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT  = 2'd2;

    localparam logic [3:0]  ENABLE_RESET  = 4'd0;
    localparam logic [15:0] PERIOD_RESET  = 16'hFFFF;
    localparam logic [31:0] TIMEOUT_RESET = 32'd100;

    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        EV_RISE     = 2'd0,
        EV_WIDTH    = 2'd1,
        EV_TIMEOUT  = 2'd2,
        EV_DISABLED = 2'd3
    } t_event_code;

    typedef struct packed {
        logic        func;
        logic [1:0]  chan;
        logic [15:0] capture_value;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_event_code event_code;
        logic [1:0]  out_chan;
        logic [16:0] pulse_width;
        logic [3:0]  lost_mask;
    } t_out_item;

endpackage
`default_nettype wire

// ----- hw/rtl/pwm_pulse_width_capture.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// PWM pulse width capture
// Per-channel high-time measurement against a free-running capture counter.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns exactly one result item for each; the
// item is held in an input register, the channel state is read and updated in
// that stage, and the result sits in an output register. A stalled result holds
// the input register and stalls the input. A capture item to an enabled
// channel alternates per channel between storing the rising count and
// computing the width (wrapped widths add timer_period + 1); a timeout item
// clears the width of every enabled channel whose last update is older than
// the timeout limit and flags it in lost_mask. Registers: 0 channel_enable,
// 1 timer_period, 2 timeout limit in milliseconds; write them only while no
// item is in flight.
module pwm_pulse_width_capture #(
    parameter int NUM_CHANNELS = pwpc_pkg::NUM_CHANNELS_DEF,
    parameter int COUNTER_BITS = pwpc_pkg::COUNTER_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  pwpc_pkg::t_in_item                     i_in,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output pwpc_pkg::t_out_item                    o_out,
    input  wire                                    i_cfg_we,
    input  wire  [pwpc_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [pwpc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import pwpc_pkg::*;

    localparam int NC   = NUM_CHANNELS;
    localparam int CB   = COUNTER_BITS;
    localparam int WB   = COUNTER_BITS + 1;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [31:0] PERIOD_RST32 = 32'(PERIOD_RESET);

    logic [3:0]    r_enable;
    logic [CB-1:0] r_period;
    logic [31:0]   r_timeout;

    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          r_expect_rise [NC];
    logic [CB-1:0] r_rise        [NC];
    logic [WB-1:0] r_width       [NC];
    logic [31:0]   r_stamp       [NC];

    logic          n_expect_rise [NC];
    logic [CB-1:0] n_rise        [NC];
    logic [WB-1:0] n_width       [NC];
    logic [31:0]   n_stamp       [NC];
    t_out_item     n_out;

    logic          out_free;
    logic          fire;
    logic [NC-1:0] chan_on;
    logic [31:0]   enable_ext;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign enable_ext  = 32'(r_enable);
    assign chan_on     = enable_ext[NC-1:0];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= ENABLE_RESET;
            r_period  <= PERIOD_RST32[CB-1:0];
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_ENABLE: r_enable <= i_cfg_wdata[3:0];
                CFG_TIMER_PERIOD: begin
                    r_period <= PERIOD_RST32[CB-1:0] &
                                CB'({16'd0, i_cfg_wdata[15:0]});
                end
                CFG_TIMEOUT_LIMIT:  r_timeout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // item stage: read channel state, compute result and next state
    always_comb begin
        logic [31:0]   age;
        logic [NC-1:0] lost;
        logic [31:0]   lost_ext;
        logic [31:0]   cap_ext;
        logic [CB-1:0] cap;
        logic [31:0]   chan_ext;
        logic [CH_W-1:0] idx;
        logic          chan_ok;
        logic [WB-1:0] cur_width;
        logic [WB-1:0] meas;
        logic [32:0]   width_ext;

        n_expect_rise = r_expect_rise;
        n_rise        = r_rise;
        n_width       = r_width;
        n_stamp       = r_stamp;
        lost          = '0;
        age           = '0;
        cap_ext       = 32'(r_in.capture_value);
        cap           = cap_ext[CB-1:0];
        chan_ext      = 32'(r_in.chan);
        idx           = chan_ext[CH_W-1:0];
        chan_ok       = chan_ext < 32'(NC);
        cur_width     = chan_ok ? r_width[idx] : '0;
        meas          = '0;
        width_ext     = 33'(cur_width);

        n_out.event_code  = EV_TIMEOUT;
        n_out.out_chan    = r_in.chan;
        n_out.pulse_width = '0;
        n_out.lost_mask   = '0;

        if (r_in.func == FUNC_TIMEOUT) begin
            for (int i = 0; i < NC; i++) begin
                age = r_in.now_ms - r_stamp[i];
                if (chan_on[i] && (age > r_timeout)) begin
                    n_width[i] = '0;
                    lost[i]    = 1'b1;
                end
            end
            lost_ext        = 32'(lost);
            n_out.out_chan  = '0;
            n_out.lost_mask = lost_ext[3:0];
        end else begin
            lost_ext = '0;
            if (!(chan_ok && chan_on[idx])) begin
                n_out.event_code  = EV_DISABLED;
                n_out.pulse_width = width_ext[16:0];
            end else if (r_expect_rise[idx]) begin
                n_rise[idx]        = cap;
                n_expect_rise[idx] = 1'b0;
                n_out.event_code   = EV_RISE;
                n_out.pulse_width  = width_ext[16:0];
            end else begin
                if (cap >= r_rise[idx]) begin
                    meas = {1'b0, cap - r_rise[idx]};
                end else begin
                    meas = {1'b0, r_period} + WB'(1) + {1'b0, cap} - {1'b0, r_rise[idx]};
                end
                width_ext          = 33'(meas);
                n_width[idx]       = meas;
                n_stamp[idx]       = r_in.now_ms;
                n_expect_rise[idx] = 1'b1;
                n_out.event_code   = EV_WIDTH;
                n_out.pulse_width  = width_ext[16:0];
            end
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_expect_rise[i] <= 1'b1;
                r_rise[i]        <= '0;
                r_width[i]       <= '0;
                r_stamp[i]       <= '0;
            end
        end else if (fire) begin
            r_expect_rise <= n_expect_rise;
            r_rise        <= n_rise;
            r_width       <= n_width;
            r_stamp       <= n_stamp;
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_in_valid || out_free) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
